// ----- rtl/bldc6s_pkg.sv -----
// Shared types, constants and commutation tables for the six-step bridge controller.
package bldc6s_pkg;

   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 16;
   localparam int ReqDataW  = 24;
   localparam int RspDataW  = 16;

   localparam logic [CsrIndexW-1:0] CSR_OC_LIMIT   = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_START_THR  = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_INIT_DELAY = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_MIN_DELAY  = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_DELAY_DEC  = 3'd4;
   localparam logic [CsrIndexW-1:0] CSR_STEP_COUNT = 3'd5;
   localparam logic [CsrIndexW-1:0] CSR_PWM_PERIOD = 3'd6;

   localparam logic [9:0]  RST_OC_LIMIT   = 10'd500;
   localparam logic [7:0]  RST_START_THR  = 8'd10;
   localparam logic [15:0] RST_INIT_DELAY = 16'd5000;
   localparam logic [15:0] RST_MIN_DELAY  = 16'd800;
   localparam logic [15:0] RST_DELAY_DEC  = 16'd40;
   localparam logic [9:0]  RST_STEP_COUNT = 10'd100;
   localparam logic [7:0]  RST_PWM_PERIOD = 8'd100;

   localparam logic [2:0] STEP_FIRST = 3'd1;
   localparam logic [2:0] STEP_LAST  = 3'd6;
   localparam logic [2:0] PHASE_A    = 3'b001;
   localparam logic [2:0] PHASE_B    = 3'b010;
   localparam logic [2:0] PHASE_C    = 3'b100;
   localparam logic [2:0] PHASE_NONE = 3'b000;

   typedef struct packed {
      logic [9:0]  oc_limit;
      logic [7:0]  start_thr;
      logic [15:0] init_delay;
      logic [15:0] min_delay;
      logic [15:0] delay_dec;
      logic [9:0]  step_count;
      logic [7:0]  pwm_period;
   } cfg_type;

   typedef struct packed {
      logic       duty_write;
      logic [7:0] duty_value;
      logic       bemf_edge;
      logic       pwm_tick;
      logic       us_tick;
      logic       adc_valid;
      logic [9:0] adc_value;
   } req_type;

   typedef struct packed {
      logic [2:0] high_gates;
      logic [2:0] low_gates;
      logic [2:0] comm_step;
      logic       running;
      logic       ramping;
      logic       overcurrent_trip;
   } rsp_type;

   function automatic logic [2:0] next_step(input logic [2:0] step);
      logic [2:0] res;
      if (step >= STEP_LAST || step < STEP_FIRST) begin
         res = STEP_FIRST;
      end else begin
         res = step + 3'd1;
      end
      return res;
   endfunction

   function automatic logic [2:0] high_of(input logic [2:0] step);
      logic [2:0] res;
      unique case (step)
         3'd1, 3'd2: res = PHASE_A;
         3'd3, 3'd4: res = PHASE_B;
         3'd5, 3'd6: res = PHASE_C;
         default:    res = PHASE_NONE;
      endcase
      return res;
   endfunction

   function automatic logic [2:0] low_of(input logic [2:0] step);
      logic [2:0] res;
      unique case (step)
         3'd1, 3'd6: res = PHASE_B;
         3'd2, 3'd3: res = PHASE_C;
         3'd4, 3'd5: res = PHASE_A;
         default:    res = PHASE_NONE;
      endcase
      return res;
   endfunction

endpackage

// ----- rtl/bldc6s_csr.sv -----
// Configuration register file of the six-step bridge controller.
module bldc6s_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [bldc6s_pkg::CsrIndexW-1:0] csr_index,
   input  logic [bldc6s_pkg::CsrDataW-1:0]  csr_wdata,
   output bldc6s_pkg::cfg_type           cfg
);
   import bldc6s_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OC_LIMIT:   cfg_in.oc_limit   = csr_wdata[9:0];
            CSR_START_THR:  cfg_in.start_thr  = csr_wdata[7:0];
            CSR_INIT_DELAY: cfg_in.init_delay = csr_wdata;
            CSR_MIN_DELAY:  cfg_in.min_delay  = csr_wdata;
            CSR_DELAY_DEC:  cfg_in.delay_dec  = csr_wdata;
            CSR_STEP_COUNT: cfg_in.step_count = csr_wdata[9:0];
            CSR_PWM_PERIOD: cfg_in.pwm_period = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.oc_limit   <= RST_OC_LIMIT;
         cfg_ff.start_thr  <= RST_START_THR;
         cfg_ff.init_delay <= RST_INIT_DELAY;
         cfg_ff.min_delay  <= RST_MIN_DELAY;
         cfg_ff.delay_dec  <= RST_DELAY_DEC;
         cfg_ff.step_count <= RST_STEP_COUNT;
         cfg_ff.pwm_period <= RST_PWM_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/bldc6s_core.sv -----
// Commutation, PWM, overcurrent and open-loop ramp state with its next-state logic.
module bldc6s_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  bldc6s_pkg::cfg_type  cfg,
   input  bldc6s_pkg::req_type  req,
   output bldc6s_pkg::rsp_type  rsp
);
   import bldc6s_pkg::*;

   logic [7:0]  duty_ff, duty_in;
   logic [7:0]  pwm_count_ff, pwm_count_in;
   logic [2:0]  step_ff, step_in;
   logic [2:0]  high_mask_ff, high_mask_in;
   logic [2:0]  low_gates_ff, low_gates_in;
   logic [2:0]  high_gates_ff, high_gates_in;
   logic        run_ff, run_in;
   logic        ramp_ff, ramp_in;
   logic [9:0]  ramp_index_ff, ramp_index_in;
   logic [15:0] ramp_delay_ff, ramp_delay_in;
   logic [15:0] countdown_ff, countdown_in;

   logic [7:0]  duty_a;
   logic [7:0]  duty_b;
   logic        trip;
   logic        run_a;
   logic [2:0]  low_a;
   logic [2:0]  high_a;
   logic [2:0]  step_a;
   logic [2:0]  mask_a;
   logic [2:0]  step_b;
   logic [7:0]  cnt_inc;
   logic        second_adv;
   logic [15:0] delay_shrunk;

   always_comb begin
      duty_a = req.duty_write ? req.duty_value : duty_ff;
      trip   = req.adc_valid && !ramp_ff && (req.adc_value > cfg.oc_limit);

      duty_b = trip ? 8'd0 : duty_a;
      run_a  = trip ? 1'b0 : run_ff;
      low_a  = trip ? PHASE_NONE : low_gates_ff;
      high_a = trip ? PHASE_NONE : high_gates_ff;

      step_a = req.bemf_edge ? next_step(step_ff) : step_ff;
      mask_a = req.bemf_edge ? high_of(step_a) : high_mask_ff;
      if (req.bemf_edge) begin
         low_a = low_of(step_a);
      end

      cnt_inc      = pwm_count_ff + 8'd1;
      pwm_count_in = pwm_count_ff;
      high_gates_in = high_a;
      if (req.pwm_tick) begin
         pwm_count_in = (cnt_inc >= cfg.pwm_period) ? 8'd0 : cnt_inc;
         high_gates_in = (duty_b != 8'd0 && pwm_count_in < duty_b) ? mask_a : PHASE_NONE;
      end

      delay_shrunk = (ramp_delay_ff > cfg.delay_dec) ? ramp_delay_ff - cfg.delay_dec : 16'd0;

      second_adv    = 1'b0;
      ramp_in       = ramp_ff;
      run_in        = run_a;
      ramp_index_in = ramp_index_ff;
      ramp_delay_in = ramp_delay_ff;
      countdown_in  = countdown_ff;
      step_b        = next_step(step_a);
      if (ramp_ff) begin
         if (req.us_tick) begin
            if (countdown_ff > 16'd1) begin
               countdown_in = countdown_ff - 16'd1;
            end else begin
               countdown_in = 16'd0;
               if (ramp_delay_ff > cfg.min_delay) begin
                  ramp_delay_in = delay_shrunk;
               end
               ramp_index_in = ramp_index_ff + 10'd1;
               if (duty_b == 8'd0 || ramp_index_in >= cfg.step_count) begin
                  ramp_in = 1'b0;
                  run_in  = 1'b1;
               end else begin
                  second_adv   = 1'b1;
                  countdown_in = ramp_delay_in;
               end
            end
         end
      end else if (!run_a && duty_b > cfg.start_thr) begin
         ramp_in       = 1'b1;
         ramp_index_in = 10'd0;
         ramp_delay_in = cfg.init_delay;
         countdown_in  = cfg.init_delay;
         second_adv    = 1'b1;
      end

      step_in      = second_adv ? step_b : step_a;
      high_mask_in = second_adv ? high_of(step_b) : mask_a;
      low_gates_in = second_adv ? low_of(step_b) : low_a;
      duty_in      = duty_b;

      if (!ramp_in && duty_b == 8'd0) begin
         run_in        = 1'b0;
         low_gates_in  = PHASE_NONE;
         high_gates_in = PHASE_NONE;
      end

      rsp.high_gates       = high_gates_in;
      rsp.low_gates        = low_gates_in;
      rsp.comm_step        = step_in;
      rsp.running          = run_in;
      rsp.ramping          = ramp_in;
      rsp.overcurrent_trip = trip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff       <= 8'd0;
         pwm_count_ff  <= 8'd0;
         step_ff       <= STEP_FIRST;
         high_mask_ff  <= PHASE_A;
         low_gates_ff  <= PHASE_B;
         high_gates_ff <= PHASE_NONE;
         run_ff        <= 1'b0;
         ramp_ff       <= 1'b0;
         ramp_index_ff <= 10'd0;
         ramp_delay_ff <= RST_INIT_DELAY;
         countdown_ff  <= 16'd0;
      end else if (fire) begin
         duty_ff       <= duty_in;
         pwm_count_ff  <= pwm_count_in;
         step_ff       <= step_in;
         high_mask_ff  <= high_mask_in;
         low_gates_ff  <= low_gates_in;
         high_gates_ff <= high_gates_in;
         run_ff        <= run_in;
         ramp_ff       <= ramp_in;
         ramp_index_ff <= ramp_index_in;
         ramp_delay_ff <= ramp_delay_in;
         countdown_ff  <= countdown_in;
      end
   end

endmodule

// ----- rtl/bldc6s_core_unit_placeholder_removed.sv -----
// Request input register stage of the six-step bridge controller.
module bldc6s_in_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bldc6s_pkg::ReqDataW-1:0] req_tdata,
   input  logic                            advance,
   output logic                            valid,
   output bldc6s_pkg::req_type             req
);
   import bldc6s_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type req_ff;
   req_type req_in;

   always_comb begin
      req_tready = !valid_ff || advance;
      valid_in   = req_tready ? req_tvalid : valid_ff;
      req_in.duty_write = req_tdata[0];
      req_in.duty_value = req_tdata[8:1];
      req_in.bemf_edge  = req_tdata[9];
      req_in.pwm_tick   = req_tdata[10];
      req_in.us_tick    = req_tdata[11];
      req_in.adc_valid  = req_tdata[12];
      req_in.adc_value  = req_tdata[22:13];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         req_ff <= req_in;
      end
   end

   assign valid = valid_ff;
   assign req   = req_ff;

endmodule

// ----- rtl/bldc_six_step_commutation_ctrl_unit.sv -----
// Top level of the six-step BLDC bridge controller.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  req_tdata, 24 bits
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata, 16 bits
//   csr      in         csr_wr_en              csr_index, csr_wdata
//
// One request is taken every clock while the response register is free or being
// drained; each response is registered from the request register's state update.
// The rate is set by the single pass through the state update logic between the
// request register and the response register.
// Synchronous reset clears the control state and loads the register defaults.
// A stalled response holds its data and stops the request register from moving.
module bldc_six_step_commutation_ctrl_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // duty_write[0], duty_value[8:1], bemf_edge[9], pwm_tick[10], us_tick[11],
   // adc_valid[12], adc_value[22:13], zero[23]
   input  logic [bldc6s_pkg::ReqDataW-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // gate_a_high[0], gate_a_low[1], gate_b_high[2], gate_b_low[3], gate_c_high[4],
   // gate_c_low[5], comm_step[8:6], running[9], ramping[10], overcurrent_trip[11],
   // zero[15:12]
   output logic [bldc6s_pkg::RspDataW-1:0]  rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [bldc6s_pkg::CsrIndexW-1:0] csr_index,
   input  logic [bldc6s_pkg::CsrDataW-1:0]  csr_wdata
);
   import bldc6s_pkg::*;

   cfg_type cfg;
   req_type req;
   rsp_type rsp;
   logic    req_valid;
   logic    advance;
   logic    rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;

   bldc6s_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bldc6s_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .valid      (req_valid),
      .req        (req)
   );

   bldc6s_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

   always_comb begin
      advance = req_valid && (!rsp_valid_ff || rsp_tready);
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_data_in = {4'd0, rsp.overcurrent_trip, rsp.ramping, rsp.running, rsp.comm_step,
                     rsp.low_gates[2], rsp.high_gates[2], rsp.low_gates[1],
                     rsp.high_gates[1], rsp.low_gates[0], rsp.high_gates[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/bldc6s_checker.sv -----
// Port-level checker for the six-step bridge controller and its bind statement.
module bldc6s_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [bldc6s_pkg::RspDataW-1:0]  rsp_tdata
);
   import bldc6s_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled response changed or was dropped.");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[8:6] >= STEP_FIRST) && (rsp_tdata[8:6] <= STEP_LAST))
      else $error("Commutation step out of range.");

   a_mode_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[9] && rsp_tdata[10]))
      else $error("Running and ramping reported together.");

   a_trip_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> !rsp_tdata[9] && !rsp_tdata[10])
      else $error("Overcurrent trip left the motor running or ramping.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Response valid straight after reset.");

endmodule

bind bldc_six_step_commutation_ctrl_unit bldc6s_checker u_bldc6s_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- sim/tb.sv -----
// Self-checking testbench for the six-step BLDC bridge controller, with a gate-state scoreboard.
`timescale 1ns / 1ps

import bldc6s_pkg::*;

class gate_scoreboard;
   cfg_type     cfg;
   logic [7:0]  duty;
   logic [7:0]  pwm_count;
   logic [2:0]  comm_step;
   logic [2:0]  high_mask;
   logic [2:0]  low_gates;
   logic [2:0]  high_gates;
   logic        running;
   logic        ramping;
   logic [9:0]  ramp_index;
   logic [15:0] ramp_delay;
   logic [15:0] countdown;
   logic [15:0] expected_gates[$];
   int          errors;
   int          checked;
   int          trips;
   int          ramps_finished;
   logic [2:0]  high_side[8];
   logic [2:0]  low_side[8];
   string       field_name[11];
   int          field_lsb[11];
   int          field_width[11];

   function new();
      high_side = '{PHASE_NONE, PHASE_A, PHASE_A, PHASE_B, PHASE_B, PHASE_C, PHASE_C,
                    PHASE_NONE};
      low_side = '{PHASE_NONE, PHASE_B, PHASE_C, PHASE_C, PHASE_A, PHASE_A, PHASE_B,
                   PHASE_NONE};
      field_name = '{"gate_a_high", "gate_a_low", "gate_b_high", "gate_b_low",
                     "gate_c_high", "gate_c_low", "comm_step", "running", "ramping",
                     "overcurrent_trip", "padding"};
      field_lsb = '{0, 1, 2, 3, 4, 5, 6, 9, 10, 11, 12};
      field_width = '{1, 1, 1, 1, 1, 1, 3, 1, 1, 1, 4};
      cfg = '{RST_OC_LIMIT, RST_START_THR, RST_INIT_DELAY, RST_MIN_DELAY, RST_DELAY_DEC,
              RST_STEP_COUNT, RST_PWM_PERIOD};
      duty = '0;
      pwm_count = '0;
      comm_step = STEP_FIRST;
      high_mask = PHASE_A;
      low_gates = PHASE_B;
      high_gates = PHASE_NONE;
      running = 1'b0;
      ramping = 1'b0;
      ramp_index = '0;
      ramp_delay = RST_INIT_DELAY;
      countdown = '0;
   endfunction

   function void write_register(logic [CsrIndexW-1:0] idx, logic [CsrDataW-1:0] val);
      case (idx)
         CSR_OC_LIMIT:   cfg.oc_limit = val[9:0];
         CSR_START_THR:  cfg.start_thr = val[7:0];
         CSR_INIT_DELAY: cfg.init_delay = val;
         CSR_MIN_DELAY:  cfg.min_delay = val;
         CSR_DELAY_DEC:  cfg.delay_dec = val;
         CSR_STEP_COUNT: cfg.step_count = val[9:0];
         CSR_PWM_PERIOD: cfg.pwm_period = val[7:0];
         default: ;
      endcase
   endfunction

   function void advance_step();
      if (comm_step >= STEP_LAST || comm_step < STEP_FIRST) begin
         comm_step = STEP_FIRST;
      end else begin
         comm_step = comm_step + 3'd1;
      end
      high_mask = high_side[comm_step];
      low_gates = low_side[comm_step];
   endfunction

   function void note_request(req_type r);
      logic trip;
      trip = 1'b0;
      if (r.duty_write) begin
         duty = r.duty_value;
      end
      // The current sample is ignored while the open-loop start is in progress.
      if (r.adc_valid && !ramping && r.adc_value > cfg.oc_limit) begin
         trip = 1'b1;
         duty = '0;
         running = 1'b0;
         low_gates = PHASE_NONE;
         high_gates = PHASE_NONE;
         trips++;
      end
      if (r.bemf_edge) begin
         advance_step();
      end
      if (r.pwm_tick) begin
         pwm_count = pwm_count + 8'd1;
         if (pwm_count >= cfg.pwm_period) begin
            pwm_count = '0;
         end
         high_gates = (duty != 0 && pwm_count < duty) ? high_mask : PHASE_NONE;
      end
      if (ramping) begin
         if (r.us_tick) begin
            if (countdown > 16'd1) begin
               countdown = countdown - 16'd1;
            end else begin
               countdown = '0;
               if (ramp_delay > cfg.min_delay) begin
                  ramp_delay = (ramp_delay > cfg.delay_dec) ? ramp_delay - cfg.delay_dec : '0;
               end
               ramp_index = ramp_index + 10'd1;
               if (duty == 0 || ramp_index >= cfg.step_count) begin
                  ramping = 1'b0;
                  running = 1'b1;
                  ramps_finished++;
               end else begin
                  advance_step();
                  countdown = ramp_delay;
               end
            end
         end
      end else if (!running && duty > cfg.start_thr) begin
         ramping = 1'b1;
         ramp_index = '0;
         ramp_delay = cfg.init_delay;
         advance_step();
         countdown = ramp_delay;
      end
      if (!ramping && duty == 0) begin
         running = 1'b0;
         low_gates = PHASE_NONE;
         high_gates = PHASE_NONE;
      end
      expected_gates.push_back({4'b0000, trip, ramping, running, comm_step,
                                low_gates[2], high_gates[2], low_gates[1], high_gates[1],
                                low_gates[0], high_gates[0]});
   endfunction

   function int pending();
      return expected_gates.size();
   endfunction

   function void check_response(logic [RspDataW-1:0] got);
      logic [15:0] want;
      logic [15:0] mask;
      if (expected_gates.size() == 0) begin
         errors++;
         $display("%0t: response %h arrived with no request outstanding", $time, got);
         return;
      end
      want = expected_gates.pop_front();
      checked++;
      for (int f = 0; f < 11; f++) begin
         mask = (16'd1 << field_width[f]) - 16'd1;
         if (((got >> field_lsb[f]) & mask) != ((want >> field_lsb[f]) & mask)) begin
            errors++;
            $display("%0t: response %0d %s expected %0d actual %0d", $time, checked,
                     field_name[f], (want >> field_lsb[f]) & mask,
                     (got >> field_lsb[f]) & mask);
         end
      end
   endfunction
endclass

module tb;

   localparam int QuietLimit = 4000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic [ReqDataW-1:0]  req_tdata = '0;
   logic                 rsp_tready = 1'b0;
   logic                 csr_wr_en = 1'b0;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [CsrDataW-1:0]  csr_wdata = '0;
   logic                 req_tready;
   logic                 rsp_tvalid;
   logic [RspDataW-1:0]  rsp_tdata;

   gate_scoreboard sb;
   int snd_idle_pct = 32;
   int rsp_idle_pct = 78;
   int quiet_cycles = 0;
   int requests_sent = 0;
   int settings_used = 1;

   bldc_six_step_commutation_ctrl_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata);
      end
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("Timed out after %0d cycles without a transfer.", quiet_cycles);
         $display("tb NOT OK");
         $finish;
      end
   end

   function automatic logic [ReqDataW-1:0] pack_request(req_type r);
      return {1'b0, r.adc_value, r.adc_valid, r.us_tick, r.pwm_tick, r.bemf_edge,
              r.duty_value, r.duty_write};
   endfunction

   task automatic push_request(input req_type r);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pack_request(r);
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sb.note_request(r);
      requests_sent++;
   endtask

   task automatic send_fields(input logic dw, input logic [7:0] dv, input logic bemf,
                              input logic ptick, input logic utick, input logic av,
                              input logic [9:0] aval);
      req_type r;
      r.duty_write = dw;
      r.duty_value = dv;
      r.bemf_edge = bemf;
      r.pwm_tick = ptick;
      r.us_tick = utick;
      r.adc_valid = av;
      r.adc_value = aval;
      push_request(r);
   endtask

   function automatic req_type random_request();
      req_type r;
      r.duty_write = ($urandom_range(0, 99) < 12);
      case ($urandom_range(0, 3))
         0: r.duty_value = '0;
         1: r.duty_value = 8'($urandom_range(0, sb.cfg.start_thr));
         default: r.duty_value = 8'($urandom_range(0, 255));
      endcase
      r.bemf_edge = ($urandom_range(0, 99) < 35);
      r.pwm_tick = ($urandom_range(0, 99) < 55);
      r.us_tick = ($urandom_range(0, 99) < 65);
      r.adc_valid = ($urandom_range(0, 99) < 25);
      if ($urandom_range(0, 99) < 70) begin
         r.adc_value = 10'($urandom_range(0, sb.cfg.oc_limit));
      end else begin
         r.adc_value = 10'($urandom_range(0, 1023));
      end
      return r;
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [CsrIndexW-1:0] idx, input logic [CsrDataW-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_register(idx, val);
   endtask

   task automatic write_settings(input cfg_type c);
      csr_write(CSR_OC_LIMIT, {6'd0, c.oc_limit});
      csr_write(CSR_START_THR, {8'd0, c.start_thr});
      csr_write(CSR_INIT_DELAY, c.init_delay);
      csr_write(CSR_MIN_DELAY, c.min_delay);
      csr_write(CSR_DELAY_DEC, c.delay_dec);
      csr_write(CSR_STEP_COUNT, {6'd0, c.step_count});
      csr_write(CSR_PWM_PERIOD, {8'd0, c.pwm_period});
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Lets any open-loop start run out with zero duty so the next settings begin stopped.
   task automatic settle();
      while (sb.ramping) begin
         send_fields(1'b1, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 10'd0);
      end
   endtask

   task automatic run_phase(input cfg_type c, input int n_items);
      drain();
      write_settings(c);
      for (int i = 0; i < n_items; i++) begin
         if (i == n_items / 2) begin
            drain();
         end
         push_request(random_request());
      end
      settle();
      drain();
   endtask

   initial begin
      cfg_type plan[6];
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Default settings: sample thresholds, step wrap and PWM gating below the start level.
      send_fields(1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0);
      send_fields(1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 10'd500);
      send_fields(1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 10'd501);
      send_fields(1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b1, 10'd1023);
      send_fields(1'b1, 8'd10, 1'b0, 1'b1, 1'b0, 1'b0, 10'd0);
      repeat (7) send_fields(1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0, 10'd0);
      drain();

      // Short open-loop start: ignored samples, edges during the start, delay saturation.
      write_settings('{10'd700, 8'd10, 16'd2, 16'd1, 16'd5, 10'd3, 8'd3});
      send_fields(1'b1, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0);
      send_fields(1'b0, 8'd0, 1'b1, 1'b0, 1'b1, 1'b1, 10'd1023);
      send_fields(1'b0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 10'd0);
      send_fields(1'b0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 10'd0);
      send_fields(1'b0, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0, 10'd0);
      send_fields(1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0, 10'd0);
      send_fields(1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0, 10'd0);
      send_fields(1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b1, 10'd701);
      send_fields(1'b1, 8'd20, 1'b0, 1'b0, 1'b0, 1'b0, 10'd0);
      send_fields(1'b1, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 10'd0);
      send_fields(1'b0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 10'd0);
      send_fields(1'b1, 8'd255, 1'b0, 1'b1, 1'b0, 1'b1, 10'd0);
      settle();
      drain();

      plan[0] = '{10'd300, 8'd20, 16'd6, 16'd2, 16'd1, 10'd5, 8'd16};
      plan[1] = '{10'd0, 8'd0, 16'd1, 16'd0, 16'd0, 10'd1, 8'd1};
      plan[2] = '{10'd1023, 8'd255, 16'd65535, 16'd65535, 16'd65535, 10'd1023, 8'd255};
      plan[3] = '{10'd600, 8'd50, 16'd20, 16'd3, 16'd65535, 10'd3, 8'd255};
      plan[4].oc_limit = 10'($urandom_range(0, 1023));
      plan[4].start_thr = 8'($urandom_range(0, 100));
      plan[4].init_delay = 16'($urandom_range(1, 12));
      plan[4].min_delay = 16'($urandom_range(0, 8));
      plan[4].delay_dec = 16'($urandom_range(0, 5));
      plan[4].step_count = 10'($urandom_range(1, 6));
      plan[4].pwm_period = 8'($urandom_range(1, 255));
      plan[5] = '{10'd500, 8'd10, 16'd4, 16'd1, 16'd2, 10'd8, 8'd100};

      for (int p = 0; p < 6; p++) begin
         if (p == 2) begin
            snd_idle_pct = 78;
            rsp_idle_pct = 32;
         end else if (p == 4) begin
            snd_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         run_phase(plan[p], 255);
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d requests under %0d register settings; %0d responses checked.",
               requests_sent, settings_used, sb.checked);
      $display("Saw %0d open-loop starts finish and %0d overcurrent trips; %0d mismatches.",
               sb.ramps_finished, sb.trips, sb.errors);
      if (sb.errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
